FILE: rtl/core/leader_cluster_grouping_core_defines.svh
// ----------------------------------------------------------------------------
// Leader cluster grouping assertion macros
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef LEADER_CLUSTER_GROUPING_CORE_DEFINES_SVH
`define LEADER_CLUSTER_GROUPING_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LCG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lcg_pkg.sv
// ----------------------------------------------------------------------------
// Leader cluster grouping package
// Sizes, payload types, controller state and command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lcg_pkg;

    localparam int MAX_ITEMS      = 64;
    localparam int COORD_BITS     = 16;
    localparam int CUT_BITS       = 16;
    localparam int GROUP_OUT_BITS = 6;

    localparam int IDX_BITS   = $clog2(MAX_ITEMS);
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int GRP_BITS   = IDX_BITS;
    localparam int GRPX_BITS  = (GRP_BITS > GROUP_OUT_BITS) ? GRP_BITS : GROUP_OUT_BITS;
    localparam int SQ_BITS    = 2 * CUT_BITS;
    localparam int CMP_BITS   = (COORD_BITS > CUT_BITS) ? COORD_BITS : CUT_BITS;
    localparam int ENTRY_BITS = 2 * COORD_BITS + GRP_BITS;

    localparam int MERGE_CUT_RESET_VAL = 320;
    localparam logic [CUT_BITS-1:0] MERGE_CUT_RESET = CUT_BITS'(MERGE_CUT_RESET_VAL);
    localparam logic [SQ_BITS-1:0]  CUT_SQ_RESET    =
        SQ_BITS'(MERGE_CUT_RESET_VAL * MERGE_CUT_RESET_VAL);

    typedef struct packed {
        logic                         first_of_set;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
    } item_t;

    typedef struct packed {
        logic [GROUP_OUT_BITS-1:0] group_index;
        logic                      opened_group;
        logic                      overflow;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic flush;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic all_issued;
        logic pipe_busy;
        logic hit;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/lcg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lcg_datapath.sv
// ----------------------------------------------------------------------------
// Leader cluster grouping datapath
// Center store, pipelined distance test, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lcg_pkg::dp_cmd_t                cmd,
    output lcg_pkg::dp_status_t                  status,
    input  wire lcg_pkg::item_t                  item,
    input  wire logic                            cfg_we,
    input  wire logic [lcg_pkg::CUT_BITS-1:0]    cfg_data,
    output lcg_pkg::result_t                     result
);

    localparam int CW = lcg_pkg::COORD_BITS;

    function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        d = {a[CW-1], a} - {b[CW-1], b};
        return d[CW] ? CW'(-d) : d[CW-1:0];
    endfunction

    // configuration
    logic [lcg_pkg::CUT_BITS-1:0] merge_cut_reg;
    logic [lcg_pkg::SQ_BITS-1:0]  cut_sq_reg;

    // current item and counters
    logic signed [CW-1:0]         x_reg;
    logic signed [CW-1:0]         y_reg;
    logic [lcg_pkg::CNT_BITS-1:0] item_count_reg;
    logic [lcg_pkg::CNT_BITS-1:0] group_count_reg;
    logic [lcg_pkg::CNT_BITS-1:0] scan_idx_reg;
    logic                         match_reg;
    logic [lcg_pkg::GRP_BITS-1:0] match_grp_reg;

    // compare pipeline
    logic                         p1_valid_reg;
    logic                         p2_valid_reg;
    logic                         p3_valid_reg;
    logic [lcg_pkg::CUT_BITS-1:0] dx_reg;
    logic [lcg_pkg::CUT_BITS-1:0] dy_reg;
    logic                         near2_reg;
    logic [lcg_pkg::GRP_BITS-1:0] grp2_reg;
    logic [lcg_pkg::SQ_BITS-1:0]  dx2_reg;
    logic [lcg_pkg::SQ_BITS-1:0]  dy2_reg;
    logic                         near3_reg;
    logic [lcg_pkg::GRP_BITS-1:0] grp3_reg;

    lcg_pkg::result_t             result_reg;
    lcg_pkg::result_t             result_next;

    // store
    logic                           wr_en;
    logic [lcg_pkg::ENTRY_BITS-1:0] wr_data;
    logic [lcg_pkg::ENTRY_BITS-1:0] rd_data;

    logic signed [CW-1:0]         rd_x;
    logic signed [CW-1:0]         rd_y;
    logic [lcg_pkg::GRP_BITS-1:0] rd_grp;
    logic [lcg_pkg::CMP_BITS-1:0] dx_cmp;
    logic [lcg_pkg::CMP_BITS-1:0] dy_cmp;
    logic [lcg_pkg::CMP_BITS-1:0] cut_cmp;
    logic                         near;
    logic [lcg_pkg::SQ_BITS:0]    dist_sq;
    logic                         hit;
    logic                         full;
    logic [lcg_pkg::GRP_BITS-1:0] commit_grp;
    logic [lcg_pkg::GRPX_BITS-1:0] commit_grp_ext;

    lcg_ram #(
        .WIDTH (lcg_pkg::ENTRY_BITS),
        .DEPTH (lcg_pkg::MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (item_count_reg[lcg_pkg::IDX_BITS-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.issue),
        .rd_addr (scan_idx_reg[lcg_pkg::IDX_BITS-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rd_x    = rd_data[lcg_pkg::ENTRY_BITS-1 -: CW];
        rd_y    = rd_data[lcg_pkg::GRP_BITS +: CW];
        rd_grp  = rd_data[lcg_pkg::GRP_BITS-1:0];
        dx_cmp  = lcg_pkg::CMP_BITS'(abs_diff(x_reg, rd_x));
        dy_cmp  = lcg_pkg::CMP_BITS'(abs_diff(y_reg, rd_y));
        cut_cmp = lcg_pkg::CMP_BITS'(merge_cut_reg);
        // both deltas under the cut keep the squares within range
        near    = (dx_cmp < cut_cmp) && (dy_cmp < cut_cmp);

        dist_sq = {1'b0, dx2_reg} + {1'b0, dy2_reg};
        hit     = p3_valid_reg && near3_reg && (dist_sq < {1'b0, cut_sq_reg});

        full           = (item_count_reg == lcg_pkg::CNT_BITS'(lcg_pkg::MAX_ITEMS));
        commit_grp     = match_reg ? match_grp_reg
                                   : group_count_reg[lcg_pkg::GRP_BITS-1:0];
        commit_grp_ext = lcg_pkg::GRPX_BITS'(commit_grp);

        wr_en   = cmd.commit && !full;
        wr_data = {x_reg, y_reg, commit_grp};

        if (full)
        begin
            result_next.group_index  = '0;
            result_next.opened_group = 1'b0;
            result_next.overflow     = 1'b1;
        end
        else
        begin
            result_next.group_index  = commit_grp_ext[lcg_pkg::GROUP_OUT_BITS-1:0];
            result_next.opened_group = !match_reg;
            result_next.overflow     = 1'b0;
        end

        status.full       = full;
        status.all_issued = (scan_idx_reg == item_count_reg);
        status.pipe_busy  = p1_valid_reg || p2_valid_reg || p3_valid_reg;
        status.hit        = hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_cut_reg   <= lcg_pkg::MERGE_CUT_RESET;
            cut_sq_reg      <= lcg_pkg::CUT_SQ_RESET;
            item_count_reg  <= '0;
            group_count_reg <= '0;
            scan_idx_reg    <= '0;
            match_reg       <= 1'b0;
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            p3_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                merge_cut_reg <= cfg_data;
            end
            cut_sq_reg <= merge_cut_reg * merge_cut_reg;

            if (cmd.flush || cmd.load)
            begin
                p1_valid_reg <= 1'b0;
                p2_valid_reg <= 1'b0;
                p3_valid_reg <= 1'b0;
            end
            else
            begin
                p1_valid_reg <= cmd.issue;
                p2_valid_reg <= p1_valid_reg;
                p3_valid_reg <= p2_valid_reg;
            end

            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                match_reg    <= 1'b0;
                if (item.first_of_set)
                begin
                    item_count_reg  <= '0;
                    group_count_reg <= '0;
                end
            end
            else
            begin
                if (cmd.issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                // keep the earliest matching entry only
                if (hit && !match_reg)
                begin
                    match_reg <= 1'b1;
                end
                if (cmd.commit && !full)
                begin
                    item_count_reg <= item_count_reg + 1'b1;
                    if (!match_reg)
                    begin
                        group_count_reg <= group_count_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= item.center_x;
            y_reg <= item.center_y;
        end
        if (hit && !match_reg)
        begin
            match_grp_reg <= grp3_reg;
        end
        dx_reg    <= dx_cmp[lcg_pkg::CUT_BITS-1:0];
        dy_reg    <= dy_cmp[lcg_pkg::CUT_BITS-1:0];
        near2_reg <= near;
        grp2_reg  <= rd_grp;
        dx2_reg   <= dx_reg * dx_reg;
        dy2_reg   <= dy_reg * dy_reg;
        near3_reg <= near2_reg;
        grp3_reg  <= grp2_reg;
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lcg_ctrl.sv
// ----------------------------------------------------------------------------
// Leader cluster grouping controller
// Sequences load, store scan, commit and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    output logic                     result_valid,
    input  wire logic                result_ready,
    input  wire lcg_pkg::dp_status_t status,
    output lcg_pkg::dp_cmd_t         cmd
);

    lcg_pkg::state_t state_reg;
    lcg_pkg::state_t state_next;
    logic            result_valid_reg;
    logic            result_valid_next;
    logic            out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lcg_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        out_free   = !result_valid_reg || result_ready;

        unique case (state_reg)
            lcg_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lcg_pkg::ST_SCAN;
                end
            end
            lcg_pkg::ST_SCAN:
            begin
                priority if (status.full || status.hit)
                begin
                    state_next = lcg_pkg::ST_DONE;
                end
                else if (status.all_issued && !status.pipe_busy)
                begin
                    state_next = lcg_pkg::ST_DONE;
                end
                else
                begin
                    cmd.issue = !status.all_issued;
                end
            end
            lcg_pkg::ST_DONE:
            begin
                // drop whatever is still in the compare pipeline
                cmd.flush = 1'b1;
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = lcg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcg_pkg::ST_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/leader_cluster_grouping_core.sv
// ----------------------------------------------------------------------------
// Leader cluster grouping core
// The scan runs over the stored centers and ends at the first match, or after the last
// entry with no match; an empty or full store goes straight to the result.
// One item at a time: a new item is taken only once the previous result commits; one
// comparison per cycle from the single store read port; a held result stalls the next commit.
// Reset clears the store counts and pipeline and loads merge_cut with 320.
// ----------------------------------------------------------------------------
`default_nettype none
`include "leader_cluster_grouping_core_defines.svh"

module leader_cluster_grouping_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire lcg_pkg::item_t               item,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output lcg_pkg::result_t                  result,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lcg_pkg::CUT_BITS-1:0] cfg_data
);

    lcg_pkg::dp_cmd_t    cmd;
    lcg_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    lcg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    lcg_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .item     (item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .result   (result)
    );

    `LCG_ASSERT_NOW(a_overflow_result, result_valid && result.overflow, (result.group_index == '0) && !result.opened_group, "overflow result carries a group")
    `LCG_ASSERT_NOW(a_issue_in_range, cmd.issue, !status.all_issued && !status.full, "read issued past stored count")
    `LCG_ASSERT_NOW(a_commit_out_free, cmd.commit, !result_valid || result_ready, "commit over a pending result")
    `LCG_ASSERT_NEXT(a_commit_shows, cmd.commit, result_valid, "committed result not presented")

endmodule

`default_nettype wire

FILE: sim/leader_cluster_grouping_core_tb.sv
// ----------------------------------------------------------------------------
// Leader cluster grouping core testbench
// Drives circle centers through the item channel and checks every grouping
// result against a local leader-clustering model: a directed table first
// (reset cut, coordinate extremes, the cut boundary, set markers), then
// randomized sets of centers scattered around earlier ones, under several
// merge cuts and handshake idling patterns, with one long result hold-off.
// ----------------------------------------------------------------------------
module leader_cluster_grouping_core_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 125;
    localparam int PEND_DEPTH     = 8;
    localparam int SEEN_DEPTH     = 128;
    localparam int COORD_W        = lcg_pkg::COORD_BITS;
    localparam int CUT_W          = lcg_pkg::CUT_BITS;
    localparam int GRP_OUT_W      = lcg_pkg::GROUP_OUT_BITS;

    typedef struct packed {
        lcg_pkg::item_t   it;
        logic             known;
        lcg_pkg::result_t want;
    } dir_row_t;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    lcg_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    lcg_pkg::result_t result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [CUT_W-1:0] cfg_data     = '0;

    // grouping model state
    logic signed [COORD_W-1:0] kept_x   [lcg_pkg::MAX_ITEMS];
    logic signed [COORD_W-1:0] kept_y   [lcg_pkg::MAX_ITEMS];
    int                        kept_grp [lcg_pkg::MAX_ITEMS];
    int                        n_kept   = 0;
    int                        n_groups = 0;
    logic [CUT_W-1:0]          cut_now  = lcg_pkg::MERGE_CUT_RESET;

    // expected results in transfer order
    lcg_pkg::result_t pending_want [PEND_DEPTH];
    int               pend_wr         = 0;
    int               pend_rd         = 0;
    int               fail_count      = 0;
    int               quiet_cycles    = 0;
    int               send_idle_pct   = 0;
    int               ready_stall_pct = 0;
    int               hold_requests   = 0;
    int               hold_seen       = 0;
    int               hold_left       = 0;

    // directed rows, all under the reset cut of 320
    dir_row_t dir_rows [17] = '{
        '{'{1'b0, 16'sh0000, 16'sh0000}, 1'b1, '{6'd0, 1'b1, 1'b0}},
        '{'{1'b0, 16'sd100, 16'sd100}, 1'b1, '{6'd0, 1'b0, 1'b0}},
        '{'{1'b1, 16'sd32767, 16'sd32767}, 1'b1, '{6'd0, 1'b1, 1'b0}},
        '{'{1'b0, 16'sh8000, 16'sh8000}, 1'b1, '{6'd1, 1'b1, 1'b0}},
        '{'{1'b0, 16'sh8000, 16'sh8000}, 1'b1, '{6'd1, 1'b0, 1'b0}},
        '{'{1'b0, 16'sd32448, 16'sd32767}, 1'b1, '{6'd0, 1'b0, 1'b0}},
        '{'{1'b0, 16'sd32447, 16'sd32767}, 1'b0, '0},
        '{'{1'b0, 16'sd32767, 16'sh8000}, 1'b0, '0},
        '{'{1'b0, 16'sh5555, 16'shAAAA}, 1'b0, '0},
        '{'{1'b0, 16'shAAAA, 16'sh5555}, 1'b0, '0},
        '{'{1'b0, 16'sh0001, 16'shFFFF}, 1'b0, '0},
        '{'{1'b1, 16'sh8000, 16'sd32767}, 1'b1, '{6'd0, 1'b1, 1'b0}},
        '{'{1'b0, 16'sh80E2, 16'sd32541}, 1'b0, '0},
        '{'{1'b0, 16'sh80E3, 16'sd32540}, 1'b0, '0},
        '{'{1'b1, 16'sh0000, 16'sh0000}, 1'b1, '{6'd0, 1'b1, 1'b0}},
        '{'{1'b0, 16'sh0000, 16'sd320}, 1'b0, '0},
        '{'{1'b0, 16'sh0000, 16'sd319}, 1'b0, '0}
    };

    leader_cluster_grouping_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Leader clustering: first stored center strictly inside the cut wins.
    function automatic lcg_pkg::result_t assign_group(input lcg_pkg::item_t it);
        lcg_pkg::result_t r;
        longint           dx;
        longint           dy;
        longint           c;
        int               g;
        bit               hit;
        r   = '0;
        hit = 1'b0;
        c   = longint'(cut_now);
        if (it.first_of_set)
        begin
            n_kept   = 0;
            n_groups = 0;
        end
        if (n_kept >= lcg_pkg::MAX_ITEMS)
        begin
            r.overflow = 1'b1;
            return r;
        end
        g = n_groups;
        for (int j = 0; j < n_kept && !hit; j++)
        begin
            dx = longint'(it.center_x) - longint'(kept_x[j]);
            dy = longint'(it.center_y) - longint'(kept_y[j]);
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            if (dx < c && dy < c && dx * dx + dy * dy < c * c)
            begin
                g   = kept_grp[j];
                hit = 1'b1;
            end
        end
        if (!hit)
        begin
            n_groups++;
            r.opened_group = 1'b1;
        end
        kept_x[n_kept]   = it.center_x;
        kept_y[n_kept]   = it.center_y;
        kept_grp[n_kept] = g;
        n_kept++;
        r.group_index = GRP_OUT_W'(g);
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] jitter(
        input logic signed [COORD_W-1:0] base,
        input int                        span
    );
        return COORD_W'(int'(base) + int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic signed [COORD_W-1:0] corner_coord();
        case ($urandom_range(3))
            0:       return 16'sh8000;
            1:       return 16'sd32767;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // Offer one item, with random idle cycles ahead of it, and record its grouping.
    task automatic send_item(input lcg_pkg::item_t it, input bit known,
                             input lcg_pkg::result_t want);
        lcg_pkg::result_t got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        got = assign_group(it);
        pending_want[pend_wr % PEND_DEPTH] = known ? want : got;
        pend_wr++;
    endtask

    task automatic write_cut(input logic [CUT_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cut_now = value;
    endtask

    // One set: mostly centers scattered around earlier ones, some noise and
    // stray set markers.
    task automatic play_set(input int len, input bit marked);
        logic signed [COORD_W-1:0] seen_x [SEEN_DEPTH];
        logic signed [COORD_W-1:0] seen_y [SEEN_DEPTH];
        int                        n_seen;
        lcg_pkg::item_t            it;
        int                        pick;
        int                        span;
        int                        k;
        n_seen = 0;
        for (int i = 0; i < len; i++)
        begin
            it.first_of_set = (i == 0) ? marked : ($urandom_range(39) == 0);
            pick = $urandom_range(99);
            if (n_seen == 0 || pick < 12)
            begin
                it.center_x = COORD_W'($urandom);
                it.center_y = COORD_W'($urandom);
            end
            else if (pick < 18)
            begin
                it.center_x = corner_coord();
                it.center_y = corner_coord();
            end
            else
            begin
                k    = $urandom_range(n_seen - 1);
                span = (pick < 75) ? int'(cut_now) + 2 : 3 * int'(cut_now) + 4;
                it.center_x = jitter(seen_x[k], span);
                it.center_y = jitter(seen_y[k], span);
            end
            if (n_seen < SEEN_DEPTH)
            begin
                seen_x[n_seen] = it.center_x;
                seen_y[n_seen] = it.center_y;
                n_seen++;
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // Write the cut once idle, set the idling mix, then stream sets.
    task automatic run_phase(input int cut, input int idle_pct, input int stall_pct,
                             input bit hold);
        int sent;
        int len;
        sent = 0;
        while (pend_wr != pend_rd)
            @(posedge clk);
        write_cut(CUT_W'(cut));
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        if (hold)
            hold_requests++;
        while (sent < PHASE_ITEMS)
        begin
            len = ($urandom_range(5) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 12);
            play_set(len, $urandom_range(9) != 0);
            sent += len;
        end
        item_valid <= 1'b0;
    endtask

    // Result side: long hold-off when requested, else random stalls.
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen    <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else
            result_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    always @(posedge clk)
    begin
        lcg_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                quiet_cycles = 0;
                if (pend_wr == pend_rd)
                begin
                    $error("result transfer with no grouping pending");
                    fail_count++;
                end
                else
                begin
                    want = pending_want[pend_rd % PEND_DEPTH];
                    pend_rd++;
                    if (result.group_index !== want.group_index)
                    begin
                        $error("group_index: expected %0d, got %0d",
                               want.group_index, result.group_index);
                        fail_count++;
                    end
                    if (result.opened_group !== want.opened_group)
                    begin
                        $error("opened_group: expected %0b, got %0b",
                               want.opened_group, result.opened_group);
                        fail_count++;
                    end
                    if (result.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b",
                               want.overflow, result.overflow);
                        fail_count++;
                    end
                end
            end
            else if ((item_valid && item_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].want);
        item_valid <= 1'b0;

        run_phase(0, 0, 0, 1'b0);
        run_phase(65535, 54, 0, 1'b0);
        run_phase(1, 0, 54, 1'b0);
        run_phase($urandom_range(32, 4000), 25, 25, 1'b0);
        run_phase(320, 0, 0, 1'b1);
        run_phase($urandom_range(1000, 20000), 0, 0, 1'b0);
        run_phase(320, 25, 25, 1'b0);

        while (pend_wr != pend_rd)
            @(posedge clk);
        repeat (lcg_pkg::MAX_ITEMS + 10) @(posedge clk);

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/lcg_pkg.sv
rtl/core/lcg_ram.sv
rtl/core/lcg_datapath.sv
rtl/core/lcg_ctrl.sv
rtl/core/leader_cluster_grouping_core.sv
sim/leader_cluster_grouping_core_tb.sv
